// ===== rtl/kms_pkg.sv =====
// shared types and constants for the korobov merit sum unit
// no dependencies; imported by every module of the block
package kms_pkg;

  localparam int CFG_W    = 16;
  localparam int DIM_W    = 4;
  localparam int WORD_W   = 64;
  localparam int IDX_W    = 3;
  localparam int PROD_W   = 128;
  localparam int LIMB_W   = 32;
  localparam int LIMB_LOG = 5;
  localparam int NUM_LIMB = 4;

  localparam logic [CFG_W-1:0] MODULUS_RST   = 16'd24041;
  localparam logic [DIM_W-1:0] DIMENSION_RST = 4'd8;

  typedef enum logic [0:0] {
    REG_MODULUS   = 1'b0,
    REG_DIMENSION = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [WORD_W-1:0] sum_word;
    logic [IDX_W-1:0]  word_index;
    logic              last_word;
  } result_t;

endpackage

// ===== rtl/korobov_merit_sum_unit.sv =====
// top level of the korobov lattice merit sum unit
// depends on kms_pkg, kms_front, kms_engine (with kms_square) and kms_result_q
//
// korobov merit sum: each multiplier word z pushed in yields ACC_WORDS result
// words, least significant first, holding the exact sum over k = 1..(p-1)/2 of
// the squared product of the m factors |p - 2*(z^s*k mod p)|, with modulus p and
// dimension m taken from the configuration registers at push time (dimension
// above MAX_DIM counts as MAX_DIM, a modulus below 3 gives a zero sum). the
// front keeps up to two pending multipliers, so pushes continue while the back
// end works; results drain through a two-word queue. an item first builds the
// coefficients z^s mod p, then for each point runs the factor loop of the
// 64x16 multiplier (upper half only once the product exceeds 64 bits)
// alongside the ten-step 32x32 limb squarer working on the previous point,
// then emits its ACC_WORDS words; with the reset settings an item has 12020
// points
module korobov_merit_sum_unit import kms_pkg::*; #(
  parameter int MAX_DIM   = 8,
  parameter int ACC_WORDS = 6,
  parameter int MOD_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item side
  input  logic              push,
  output logic              full,
  input  logic [CFG_W-1:0]  multiplier_i,
  // result side
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] sum_word_o,
  output logic [IDX_W-1:0]  word_index_o,
  output logic              last_word_o,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  logic                job_valid, job_ready;
  logic [MOD_BITS-1:0] job_z, job_p;
  logic [DIM_W-1:0]    job_m;
  logic [MOD_BITS-2:0] job_npts;
  logic                res_push, res_full;
  result_t             res_in, res_out;

  // intake and job queue
  kms_front #(
    .MOD_BITS (MOD_BITS),
    .MAX_DIM  (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .multiplier_i (multiplier_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_z_o      (job_z),
    .job_p_o      (job_p),
    .job_m_o      (job_m),
    .job_npts_o   (job_npts)
  );

  // coefficient, product and square-accumulate engine
  kms_engine #(
    .MOD_BITS  (MOD_BITS),
    .MAX_DIM   (MAX_DIM),
    .ACC_WORDS (ACC_WORDS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_z_i     (job_z),
    .job_p_i     (job_p),
    .job_m_i     (job_m),
    .job_npts_i  (job_npts),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .res_data_o  (res_in)
  );

  // output word queue
  kms_result_q u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_out)
  );

  assign sum_word_o   = res_out.sum_word;
  assign word_index_o = res_out.word_index;
  assign last_word_o  = res_out.last_word;

endmodule

// ===== rtl/kms_front.sv =====
// front end: configuration registers, item intake and a two-entry job queue
// depends on kms_pkg
module kms_front import kms_pkg::*; #(
  parameter int MOD_BITS = 16,
  parameter int MAX_DIM  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [CFG_W-1:0]    multiplier_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output logic [MOD_BITS-1:0] job_z_o,
  output logic [MOD_BITS-1:0] job_p_o,
  output logic [DIM_W-1:0]    job_m_o,
  output logic [MOD_BITS-2:0] job_npts_o
);

  logic [CFG_W-1:0]    modulus_q;
  logic [DIM_W-1:0]    dimension_q;
  logic [MOD_BITS-1:0] z_q    [2];
  logic [MOD_BITS-1:0] p_q    [2];
  logic [DIM_W-1:0]    m_q    [2];
  logic [MOD_BITS-2:0] npts_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q;
  logic                do_push, do_pop;
  logic [MOD_BITS-1:0] p_cur, p_dec;
  logic [DIM_W-1:0]    m_cur;
  logic [MOD_BITS-2:0] npts_cur;

  assign cfg_ready_o = 1'b1;
  assign full        = (count_q == 2'd2);
  assign job_valid_o = (count_q != 2'd0);
  assign do_push     = push && !full;
  assign do_pop      = job_valid_o && job_ready_i;

  // classify the item against the current settings
  always_comb begin
    p_cur    = modulus_q[MOD_BITS-1:0];
    p_dec    = p_cur - MOD_BITS'(1);
    m_cur    = (dimension_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dimension_q;
    npts_cur = (p_cur >= MOD_BITS'(3)) ? p_dec[MOD_BITS-1:1] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= MODULUS_RST;
      dimension_q <= DIMENSION_RST;
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      count_q     <= 2'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_MODULUS:   modulus_q   <= cfg_data_i;
          REG_DIMENSION: dimension_q <= cfg_data_i[DIM_W-1:0];
          default:       modulus_q   <= modulus_q;
        endcase
      end
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop)      count_q <= count_q + 2'd1;
      else if (!do_push && do_pop) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      z_q[wr_ptr_q]    <= multiplier_i[MOD_BITS-1:0];
      p_q[wr_ptr_q]    <= p_cur;
      m_q[wr_ptr_q]    <= m_cur;
      npts_q[wr_ptr_q] <= npts_cur;
    end
  end

  assign job_z_o    = z_q[rd_ptr_q];
  assign job_p_o    = p_q[rd_ptr_q];
  assign job_m_o    = m_q[rd_ptr_q];
  assign job_npts_o = npts_q[rd_ptr_q];

endmodule

// ===== rtl/kms_square.sv =====
// squaring accumulator: squares a 128-bit product by 32-bit limbs and adds it in
// depends on kms_pkg
module kms_square import kms_pkg::*; #(
  parameter int ACC_WORDS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          load_i,
  input  logic [PROD_W-1:0]             prod_i,
  output logic                          ready_o,
  output logic                          busy_o,
  input  logic [$clog2(ACC_WORDS)-1:0]  word_sel_i,
  output logic [WORD_W-1:0]             word_o
);

  localparam int ACC_W = ACC_WORDS * WORD_W;

  logic [PROD_W-1:0]   a_q;
  logic                act_q, mv_q;
  logic [1:0]          i_q, j_q;
  logic [WORD_W-1:0]   mul_q;
  logic [2:0]          sh_q;
  logic                dbl_q;
  logic [ACC_W-1:0]    acc_q;
  logic [WORD_W:0]     term;
  logic [ACC_W-1:0]    addend;

  assign ready_o = !act_q;
  assign busy_o  = act_q || mv_q;
  assign word_o  = acc_q[word_sel_i*WORD_W +: WORD_W];

  // off-diagonal limb pairs count twice
  always_comb begin
    term   = dbl_q ? {mul_q, 1'b0} : {1'b0, mul_q};
    addend = ACC_W'(term) << (8'(sh_q) << LIMB_LOG);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      mv_q  <= 1'b0;
      i_q   <= '0;
      j_q   <= '0;
    end else begin
      mv_q <= act_q;
      if (load_i) begin
        act_q <= 1'b1;
        i_q   <= '0;
        j_q   <= '0;
      end else if (act_q) begin
        if (j_q == 2'(NUM_LIMB - 1)) begin
          if (i_q == 2'(NUM_LIMB - 1)) act_q <= 1'b0;
          i_q <= i_q + 2'd1;
          j_q <= i_q + 2'd1;
        end else begin
          j_q <= j_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) a_q <= prod_i;
    mul_q <= a_q[i_q*LIMB_W +: LIMB_W] * WORD_W'(a_q[j_q*LIMB_W +: LIMB_W]);
    sh_q  <= 3'(i_q) + 3'(j_q);
    dbl_q <= (i_q != j_q);
    if (clear_i)   acc_q <= '0;
    else if (mv_q) acc_q <= acc_q + addend;
  end

endmodule

// ===== rtl/kms_result_q.sv =====
// two-entry result queue in front of the output ports
// depends on kms_pkg
module kms_result_q import kms_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop)      count_q <= count_q + 2'd1;
      else if (!do_push && do_pop) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== rtl/kms_engine.sv =====
// back end: coefficient sequencer, point/factor product loop, word emission
// depends on kms_pkg and kms_square
module kms_engine import kms_pkg::*; #(
  parameter int MOD_BITS  = 16,
  parameter int MAX_DIM   = 8,
  parameter int ACC_WORDS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  logic [MOD_BITS-1:0] job_z_i,
  input  logic [MOD_BITS-1:0] job_p_i,
  input  logic [DIM_W-1:0]    job_m_i,
  input  logic [MOD_BITS-2:0] job_npts_i,
  output logic                res_push_o,
  input  logic                res_full_i,
  output result_t             res_data_o
);

  localparam int SW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int HB_W  = $clog2(MOD_BITS);
  localparam int WIX_W = $clog2(ACC_WORDS);
  localparam int HI_S  = WORD_W / MOD_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COEF, ST_PREP, ST_RUN, ST_DRAIN, ST_EMIT
  } state_e;

  state_e              state_q;
  logic                pv_q, half_q;
  logic [SW-1:0]       s_q;
  logic [HB_W-1:0]     hb_q;
  logic [MOD_BITS-2:0] k_q, npts_q;
  logic [WIX_W-1:0]    widx_q;
  logic [MOD_BITS-1:0] p_q, z_q, f_q, carry_q, r_q, prev_q;
  logic [DIM_W-1:0]    m_q;
  logic [MOD_BITS-1:0] coef_q [MAX_DIM];
  logic [MOD_BITS-1:0] dres_q [MAX_DIM];
  logic [PROD_W-1:0]   prod_q;

  logic                    start, last_s, need_hi, sq_ready, sq_busy, sq_load;
  logic [SW-1:0]           nxt_idx;
  logic [MOD_BITS:0]       pe, dsum, dn, two, r2, r2m, r3, r3m;
  logic [MOD_BITS-1:0]     fval;
  logic [WORD_W+MOD_BITS-1:0] lo_prod;
  logic [WORD_W-1:0]       hi_res, sq_word;
  logic                    chunk_end, emit;

  assign start       = (state_q == ST_IDLE) && job_valid_i;
  assign job_ready_o = (state_q == ST_IDLE);
  assign sq_load     = (state_q == ST_RUN) && pv_q && sq_ready;
  assign emit        = (state_q == ST_EMIT) && !res_full_i;

  always_comb begin
    pe      = {1'b0, p_q};
    last_s  = (DIM_W'(s_q) == m_q - DIM_W'(1));
    nxt_idx = ((state_q == ST_PREP) || last_s) ? '0 : s_q + SW'(1);
    // next residue c*k mod p by one add and fold, then the factor |p - 2d|
    dsum = {1'b0, dres_q[nxt_idx]} + {1'b0, coef_q[nxt_idx]};
    dn   = (dsum >= pe) ? dsum - pe : dsum;
    two  = {dn[MOD_BITS-1:0], 1'b0};
    fval = (two >= pe) ? MOD_BITS'(two - pe) : MOD_BITS'(pe - two);
    // one horner step of prev * z mod p
    r2  = {r_q, 1'b0};
    r2m = (r2 >= pe) ? r2 - pe : r2;
    r3  = r2m + (z_q[hb_q] ? {1'b0, prev_q} : '0);
    r3m = (r3 >= pe) ? r3 - pe : r3;
    // product times factor, lower then upper 64 bits
    lo_prod   = prod_q[WORD_W-1:0] * (WORD_W+MOD_BITS)'(f_q);
    hi_res    = prod_q[PROD_W-1:WORD_W] * WORD_W'(f_q) + WORD_W'(carry_q);
    need_hi   = (int'(s_q) > HI_S);
    chunk_end = half_q || !need_hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pv_q    <= 1'b0;
      half_q  <= 1'b0;
      s_q     <= '0;
      hb_q    <= '0;
      k_q     <= '0;
      widx_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            s_q  <= SW'(1);
            hb_q <= HB_W'(MOD_BITS - 1);
            if (job_npts_i == '0) begin
              widx_q  <= '0;
              state_q <= ST_EMIT;
            end else if (job_m_i >= DIM_W'(2)) begin
              state_q <= ST_COEF;
            end else begin
              state_q <= ST_PREP;
            end
          end
        end
        ST_COEF: begin
          hb_q <= hb_q - HB_W'(1);
          if (hb_q == '0) begin
            hb_q <= HB_W'(MOD_BITS - 1);
            if (last_s) state_q <= ST_PREP;
            else        s_q     <= s_q + SW'(1);
          end
        end
        ST_PREP: begin
          s_q     <= '0;
          half_q  <= 1'b0;
          pv_q    <= 1'b0;
          k_q     <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (pv_q) begin
            if (sq_ready) begin
              pv_q <= 1'b0;
              if (k_q == npts_q) state_q <= ST_DRAIN;
            end
          end else if (m_q == '0) begin
            pv_q <= 1'b1;
            k_q  <= k_q + 1'b1;
          end else if (!chunk_end) begin
            half_q <= 1'b1;
          end else begin
            half_q <= 1'b0;
            if (last_s) begin
              s_q  <= '0;
              pv_q <= 1'b1;
              k_q  <= k_q + 1'b1;
            end else begin
              s_q <= s_q + SW'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (!sq_busy) begin
            widx_q  <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!res_full_i) begin
            widx_q <= widx_q + WIX_W'(1);
            if (widx_q == WIX_W'(ACC_WORDS - 1)) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (start) begin
      p_q    <= job_p_i;
      z_q    <= job_z_i;
      m_q    <= job_m_i;
      npts_q <= job_npts_i;
      prev_q <= MOD_BITS'(1);
      r_q    <= '0;
      for (int i = 0; i < MAX_DIM; i++) dres_q[i] <= '0;
      coef_q[0] <= MOD_BITS'(1);
    end
    if (state_q == ST_COEF) begin
      r_q <= r3m[MOD_BITS-1:0];
      if (hb_q == '0) begin
        coef_q[s_q] <= r3m[MOD_BITS-1:0];
        prev_q      <= r3m[MOD_BITS-1:0];
        r_q         <= '0;
      end
    end
    if (state_q == ST_PREP) begin
      f_q             <= fval;
      dres_q[nxt_idx] <= dn[MOD_BITS-1:0];
      prod_q          <= PROD_W'(1);
    end
    if (state_q == ST_RUN) begin
      if (sq_load) begin
        prod_q <= PROD_W'(1);
      end else if (!pv_q && (m_q != '0)) begin
        if (!half_q) begin
          prod_q[WORD_W-1:0] <= lo_prod[WORD_W-1:0];
          carry_q            <= lo_prod[WORD_W +: MOD_BITS];
          if (!need_hi) prod_q[PROD_W-1:WORD_W] <= WORD_W'(lo_prod[WORD_W +: MOD_BITS]);
        end else begin
          prod_q[PROD_W-1:WORD_W] <= hi_res;
        end
        if (chunk_end) begin
          f_q             <= fval;
          dres_q[nxt_idx] <= dn[MOD_BITS-1:0];
        end
      end
    end
  end

  kms_square #(
    .ACC_WORDS (ACC_WORDS)
  ) u_square (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (start),
    .load_i     (sq_load),
    .prod_i     (prod_q),
    .ready_o    (sq_ready),
    .busy_o     (sq_busy),
    .word_sel_i (widx_q),
    .word_o     (sq_word)
  );

  assign res_push_o            = emit;
  assign res_data_o.sum_word   = sq_word;
  assign res_data_o.word_index = IDX_W'(widx_q);
  assign res_data_o.last_word  = (widx_q == WIX_W'(ACC_WORDS - 1));

endmodule

// ===== verif/korobov_merit_sum_unit_tb.sv =====
// testbench for the korobov lattice merit sum unit: directed table, then random phases
// depends on kms_pkg and the korobov_merit_sum_unit rtl; self-checking, no files read
module korobov_merit_sum_unit_tb;
  import kms_pkg::*;

  localparam int NUM_WORDS = 6;
  localparam int MAX_FACT  = 8;
  localparam int IDLE_PCT  = 11;
  localparam int SETTLE    = 40;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [CFG_W-1:0]  multiplier_i;
  logic              empty;
  logic              pop;
  logic [WORD_W-1:0] sum_word_o;
  logic [IDX_W-1:0]  word_index_o;
  logic              last_word_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [0:0]        cfg_index_i;
  logic [CFG_W-1:0]  cfg_data_i;

  korobov_merit_sum_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .multiplier_i(multiplier_i),
    .empty(empty), .pop(pop),
    .sum_word_o(sum_word_o), .word_index_o(word_index_o), .last_word_o(last_word_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // 8 unit clock period
  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // mirror of the configuration registers
  logic [CFG_W-1:0] mod_reg;
  logic [DIM_W-1:0] dim_reg;

  // expected result words, oldest first
  result_t pending_words[$];
  int      mismatches;
  bit      calm;          // no idling on either side while set
  int      hold_left;     // receiver hold-off, counted down in its own process

  // exact merit sum: sum over points of the squared product of folded distances
  function automatic logic [383:0] merit_sum(logic [CFG_W-1:0] p_in, logic [DIM_W-1:0] dim,
                                             logic [CFG_W-1:0] z);
    int unsigned coef[MAX_FACT];
    int unsigned p, npts, m, d, f;
    logic [127:0] prod;
    logic [255:0] sq;
    logic [383:0] acc;
    p    = p_in;
    m    = (dim > MAX_FACT) ? MAX_FACT : dim;
    npts = (p >= 3) ? (p - 1) / 2 : 0;
    acc  = '0;
    if (npts != 0) begin
      coef[0] = 1;
      for (int s = 1; s < m; s++) coef[s] = (coef[s-1] * z) % p;
      for (int unsigned k = 1; k <= npts; k++) begin
        prod = 128'd1;
        for (int s = 0; s < m; s++) begin
          d = (coef[s] * k) % p;
          // distance to the midpoint p/2, doubled
          f = (2 * d >= p) ? 2 * d - p : p - 2 * d;
          prod = prod * 128'(f);
        end
        sq  = 256'(prod) * 256'(prod);
        acc = acc + 384'(sq);
      end
    end
    return acc;
  endfunction

  // split a sum into its six words, least significant first
  function automatic void queue_sum(logic [383:0] sum);
    result_t w;
    for (int i = 0; i < NUM_WORDS; i++) begin
      w.sum_word   = sum[i*WORD_W +: WORD_W];
      w.word_index = IDX_W'(i);
      w.last_word  = (i == NUM_WORDS - 1);
      pending_words.push_back(w);
    end
  endfunction

  // offer one multiplier word; the sum is queued when the word is taken
  task automatic send_multiplier(logic [CFG_W-1:0] z, logic [383:0] sum);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    multiplier_i <= z;
    @(negedge clk_i);
    while (full) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    queue_sum(sum);
    @(posedge clk_i);
  endtask

  // wait until every expected word has been read, then let the block settle
  task automatic drain_results();
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_MODULUS) mod_reg = data;
    else                    dim_reg = data[DIM_W-1:0];
    @(posedge clk_i);
  endtask

  // called only when idle; upper data bits are random to exercise masking
  task automatic set_config(logic [CFG_W-1:0] p, logic [DIM_W-1:0] d);
    if (p != mod_reg) write_reg(REG_MODULUS, p);
    if (d != dim_reg) write_reg(REG_DIMENSION, {12'($urandom), d});
  endtask

  // directed table: known rows carry a sum read off directly
  typedef struct {
    logic [CFG_W-1:0] p;
    logic [DIM_W-1:0] d;
    logic [CFG_W-1:0] z;
    bit               known;
    logic [383:0]     sum;
  } stim_row_t;

  stim_row_t table_rows[] = '{
    '{16'd24041, 4'd8,  16'd12,    1'b0, '0},  // reset settings
    '{16'd0,     4'd8,  16'd5,     1'b1, '0},  // small modulus, no points
    '{16'd1,     4'd3,  16'hFFFF,  1'b1, '0},
    '{16'd2,     4'd3,  16'd1,     1'b1, '0},
    '{16'd7,     4'd0,  16'd9,     1'b1, 384'd3},   // dimension zero: sum is point count
    '{16'd201,   4'd0,  16'd0,     1'b1, 384'd100},
    '{16'd3,     4'd1,  16'd0,     1'b1, 384'd1},   // single point, single factor
    '{16'd11,    4'd15, 16'hFFFF,  1'b0, '0},  // dimension saturates, z above modulus
    '{16'd11,    4'd9,  16'd3,     1'b0, '0},
    '{16'd10,    4'd3,  16'd7,     1'b0, '0},  // even modulus
    '{16'd13,    4'd8,  16'd0,     1'b0, '0},
    '{16'd13,    4'd8,  16'd1,     1'b0, '0},
    '{16'd13,    4'd8,  16'd12,    1'b0, '0},
    '{16'd101,   4'd4,  16'd13,    1'b0, '0},
    '{16'd101,   4'd4,  16'd200,   1'b0, '0},
    '{16'd255,   4'd2,  16'h5AA5,  1'b0, '0},
    '{16'd65535, 4'd8,  16'hFFFF,  1'b0, '0}   // widest modulus and sum
  };

  // receiver: random pop, with a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pop <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare each word read against the oldest expectation
  always @(negedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: sum %h index %0d last %0b",
                   sum_word_o, word_index_o, last_word_o);
      end else begin
        result_t w;
        w = pending_words.pop_front();
        if (sum_word_o !== w.sum_word || word_index_o !== w.word_index ||
            last_word_o !== w.last_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                     w.sum_word, w.word_index, w.last_word,
                     sum_word_o, word_index_o, last_word_o);
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] p;
    logic [DIM_W-1:0] d;
    logic [CFG_W-1:0] z;
    int               sel;
    int               item_no;
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    multiplier_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    mismatches   = 0;
    calm         = 1'b0;
    hold_left    = 0;
    mod_reg      = MODULUS_RST;
    dim_reg      = DIMENSION_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part; config changes only after the block has drained
    foreach (table_rows[i]) begin
      if (table_rows[i].p != mod_reg || table_rows[i].d != dim_reg) begin
        drain_results();
        set_config(table_rows[i].p, table_rows[i].d);
      end
      send_multiplier(table_rows[i].z, table_rows[i].known ? table_rows[i].sum :
                      merit_sum(mod_reg, dim_reg, table_rows[i].z));
    end

    // random phases of a few items each, mostly small moduli to keep items short
    item_no = 0;
    while (item_no < 100) begin
      drain_results();
      sel = $urandom_range(19);
      if (sel == 0)      p = $urandom_range(2);
      else if (sel == 1) p = $urandom_range(600, 300);
      else               p = $urandom_range(250, 3);
      d = $urandom_range(15);
      set_config(p, d);
      if (item_no == 16) hold_left = 6000;   // block fills and stalls its input
      for (int j = 0; j < 8 && item_no < 100; j++) begin
        calm = (item_no >= 50 && item_no < 70);
        z = (j == 0) ? 16'($urandom) : ($urandom_range(3) == 0 ? 16'($urandom) :
             16'($urandom_range(p)));
        send_multiplier(z, merit_sum(mod_reg, dim_reg, z));
        item_no++;
      end
    end

    drain_results();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("korobov_merit_sum_unit test passed");
    end else begin
      $display("korobov_merit_sum_unit test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #80_000_000;
    $display("korobov_merit_sum_unit test failed");
    $finish;
  end

endmodule

// ===== korobov_merit_sum_unit.f =====
rtl/kms_pkg.sv
rtl/kms_front.sv
rtl/kms_square.sv
rtl/kms_result_q.sv
rtl/kms_engine.sv
rtl/korobov_merit_sum_unit.sv
verif/korobov_merit_sum_unit_tb.sv
